>>> rtl/core/qga_pkg.sv
// ----------------------------------------------------------------------------
// qga_pkg
// Types, constants and the Hamilton product term table shared by the
// gyro attitude update core and its multiplier unit.
// ----------------------------------------------------------------------------
package qga_pkg;

  localparam int QUAT_W   = 32;   // Q1.30 quaternion component
  localparam int RATE_W   = 24;   // Q6.17 gyro rate
  localparam int PERIOD_W = 24;   // Q0.24 sample period
  localparam int SUM_W    = 38;   // quaternion plus step, with headroom
  localparam int DQ_W     = 40;   // Hamilton sum rounded to Q.30
  localparam int MUL_W    = 33;   // signed operand width of the shared multiplier
  localparam int PROD_W   = 2 * MUL_W;

  localparam logic signed [QUAT_W-1:0] ONE_Q = 32'sh4000_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd16777;

  // payload of one input beat
  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } gyro_sample_t;

  // payload of one output beat
  typedef struct packed {
    logic signed [QUAT_W-1:0] att_w;
    logic signed [QUAT_W-1:0] att_x;
    logic signed [QUAT_W-1:0] att_y;
    logic signed [QUAT_W-1:0] att_z;
    logic                     degenerate;
  } attitude_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HAM,
    ST_SQLO,
    ST_NORM,
    ST_SQHI,
    ST_SQRT,
    ST_DIV,
    ST_FIN
  } seq_state_t;

  // one term of the Hamilton product q * (0, gx, gy, gz)
  typedef struct packed {
    logic [1:0] q_sel;
    logic [1:0] r_sel;
    logic       neg;
  } ham_term_t;

  function automatic ham_term_t ham_term(input logic [1:0] comp, input logic [1:0] term);
    ham_term_t t;
    t = '{q_sel: 2'd0, r_sel: 2'd0, neg: 1'b0};
    unique case ({comp, term})
      4'b00_00: t = '{q_sel: 2'd1, r_sel: 2'd0, neg: 1'b1};
      4'b00_01: t = '{q_sel: 2'd2, r_sel: 2'd1, neg: 1'b1};
      4'b00_10: t = '{q_sel: 2'd3, r_sel: 2'd2, neg: 1'b1};
      4'b01_00: t = '{q_sel: 2'd0, r_sel: 2'd0, neg: 1'b0};
      4'b01_01: t = '{q_sel: 2'd2, r_sel: 2'd2, neg: 1'b0};
      4'b01_10: t = '{q_sel: 2'd3, r_sel: 2'd1, neg: 1'b1};
      4'b10_00: t = '{q_sel: 2'd0, r_sel: 2'd1, neg: 1'b0};
      4'b10_01: t = '{q_sel: 2'd1, r_sel: 2'd2, neg: 1'b1};
      4'b10_10: t = '{q_sel: 2'd3, r_sel: 2'd0, neg: 1'b0};
      4'b11_00: t = '{q_sel: 2'd0, r_sel: 2'd2, neg: 1'b0};
      4'b11_01: t = '{q_sel: 2'd1, r_sel: 2'd1, neg: 1'b0};
      4'b11_10: t = '{q_sel: 2'd2, r_sel: 2'd0, neg: 1'b1};
      default:  t = '{q_sel: 2'd0, r_sel: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/quat_gyro_attitude_update_core.sv
// One sample is processed at a time; a summed quaternion near zero skips the
// normalisation and goes straight to the output beat.
// Steps: Hamilton product and period scaling on the shared multiplier, sums of
// squares, normalising shifts, 32 square root steps and restoring division
// steps for each of the four components.
// Reset (rst, synchronous): attitude returns to identity, period to 16777.
// ----------------------------------------------------------------------------
// quat_gyro_attitude_update_core
// First-order gyro integration of an attitude quaternion with renormalisation,
// sequenced over one shared multiplier and bit-serial root and divide steps.
// ----------------------------------------------------------------------------
module quat_gyro_attitude_update_core
  import qga_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gyro_sample_t        in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output attitude_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  seq_state_t state, state_next;

  logic [PERIOD_W-1:0]      period;
  logic signed [QUAT_W-1:0] q [4];
  gyro_sample_t             smp;
  logic [1:0]               comp;
  logic [2:0]               k;
  logic                     ph;
  logic [5:0]               cnt;
  logic signed [63:0]       acc;
  logic signed [DQ_W-1:0]   dq;
  logic [SUM_W-1:0]         mag [4];
  logic [3:0]               neg;
  logic [63:0]              ss;
  logic [63:0]              sq_v, sq_r, sq_bit;
  logic [31:0]              nrt;
  logic [31:0]              rem;
  logic [30:0]              dsh, quo;
  logic                     deg_flag;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod;

  ham_term_t                term;
  logic signed [RATE_W-1:0] rate_pick;
  logic [SUM_W-1:0]         m_max;
  logic signed [63:0]       sp, acc_sum, acc_rnd, t_sum, t_rnd;
  logic signed [SUM_W-1:0]  stp, sum_val;
  logic [63:0]              ss_next, sq_try;
  logic [61:0]              numer;
  logic [32:0]              d_try;
  logic [30:0]              quo_next;
  logic [31:0]              rem_next;
  logic                     ham_done, sq_done, sqrt_done, div_done, fin_go;

  qga_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // term table and rate pick
  always_comb begin
    term = ham_term(comp, k[1:0]);
    unique case (term.r_sel)
      2'd0:    rate_pick = smp.rate_x;
      2'd1:    rate_pick = smp.rate_y;
      default: rate_pick = smp.rate_z;
    endcase
  end

  // largest magnitude
  always_comb begin
    m_max = mag[0];
    for (int i = 1; i < 4; i++) begin
      if (mag[i] > m_max) m_max = mag[i];
    end
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      ST_HAM: begin
        if (k < 3'd3) begin
          op_a = {q[term.q_sel][QUAT_W-1], q[term.q_sel]};
          op_b = {{(MUL_W-RATE_W){rate_pick[RATE_W-1]}}, rate_pick};
        end else if (k == 3'd3) begin
          op_a = {{(MUL_W-24){dq[DQ_W-1]}}, dq[DQ_W-1:16]};
          op_b = {{(MUL_W-PERIOD_W){1'b0}}, period};
        end else begin
          op_a = {{(MUL_W-16){1'b0}}, dq[15:0]};
          op_b = {{(MUL_W-PERIOD_W){1'b0}}, period};
        end
      end
      ST_SQLO: begin
        op_a = {{(MUL_W-11){1'b0}}, mag[comp][10:0]};
        op_b = {{(MUL_W-11){1'b0}}, mag[comp][10:0]};
      end
      ST_SQHI: begin
        op_a = {{(MUL_W-31){1'b0}}, mag[comp][30:0]};
        op_b = {{(MUL_W-31){1'b0}}, mag[comp][30:0]};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // accumulate, rounding and step arithmetic
  always_comb begin
    sp      = term.neg ? -prod[63:0] : prod[63:0];
    acc_sum = ((k == 3'd0) ? 64'sd0 : acc) + sp;
    acc_rnd = acc_sum + 64'sd65536;
    t_sum   = acc + prod[63:0];
    t_rnd   = t_sum + 64'sd16777216;
    stp     = t_rnd[62:25];
    sum_val = {{(SUM_W-QUAT_W){q[comp][QUAT_W-1]}}, q[comp]} + stp;
    ss_next = ss + prod[63:0];
    sq_try  = sq_r + sq_bit;
    numer   = {1'b0, mag[comp][30:0], 30'd0} + {31'd0, nrt[31:1]};
    d_try   = {rem, dsh[30]};
    if (d_try >= {1'b0, nrt}) begin
      rem_next = 32'(d_try - {1'b0, nrt});
      quo_next = {quo[29:0], 1'b1};
    end else begin
      rem_next = d_try[31:0];
      quo_next = {quo[29:0], 1'b0};
    end
  end

  // phase end flags
  assign ham_done  = ph && (k == 3'd4) && (comp == 2'd3);
  assign sq_done   = ph && (comp == 2'd3);
  assign sqrt_done = (cnt == 6'd31);
  assign div_done  = (cnt == 6'd31) && (comp == 2'd3);
  assign fin_go    = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_HAM;
      ST_HAM:  if (ham_done) state_next = ST_SQLO;
      ST_SQLO: begin
        if (sq_done) begin
          if ((m_max < SUM_W'(2048)) && (ss_next < 64'd1048576)) state_next = ST_FIN;
          else state_next = ST_NORM;
        end
      end
      ST_NORM: if ((m_max[SUM_W-1:31] == '0) && m_max[30]) state_next = ST_SQHI;
      ST_SQHI: if (sq_done) state_next = ST_SQRT;
      ST_SQRT: if (sqrt_done) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FIN;
      ST_FIN:  if (fin_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      period    <= PERIOD_RST;
      q[0]      <= ONE_Q;
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
      out_valid <= 1'b0;
      comp      <= '0;
      k         <= '0;
      ph        <= 1'b0;
      cnt       <= '0;
      deg_flag  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) period <= cfg_data;
      // output beat raised on a finished sample, dropped once taken
      if ((state == ST_FIN) && fin_go) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          comp <= '0;
          k    <= '0;
          ph   <= 1'b0;
          cnt  <= '0;
        end
        ST_HAM: begin
          ph <= !ph;
          if (ph) begin
            if (k == 3'd4) begin
              k    <= '0;
              comp <= comp + 2'd1;
            end else begin
              k <= k + 3'd1;
            end
          end
        end
        ST_SQLO, ST_SQHI: begin
          ph <= !ph;
          if (ph) comp <= comp + 2'd1;
          if (sq_done) cnt <= '0;
          if ((state == ST_SQLO) && (state_next == ST_FIN)) begin
            q[0]     <= ONE_Q;
            q[1]     <= '0;
            q[2]     <= '0;
            q[3]     <= '0;
            deg_flag <= 1'b1;
          end
        end
        ST_SQRT: begin
          cnt <= sqrt_done ? 6'd0 : cnt + 6'd1;
          comp <= '0;
        end
        ST_DIV: begin
          if (cnt == 6'd31) begin
            q[comp] <= neg[comp] ? -QUAT_W'({1'b0, quo_next}) : QUAT_W'({1'b0, quo_next});
            cnt      <= '0;
            comp     <= comp + 2'd1;
            deg_flag <= 1'b0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) smp <= in_data;
    unique case (state)
      ST_IDLE: ss <= '0;
      ST_HAM: begin
        if (ph) begin
          if (k < 3'd3) begin
            acc <= acc_sum;
            if (k == 3'd2) dq <= acc_rnd[56:17];
          end else if (k == 3'd3) begin
            acc <= prod[63:0] <<< 16;
          end else begin
            neg[comp] <= sum_val[SUM_W-1];
            mag[comp] <= sum_val[SUM_W-1] ? SUM_W'(-sum_val) : SUM_W'(sum_val);
          end
        end
        ss <= '0;
      end
      ST_SQLO: if (ph) ss <= sq_done ? 64'd0 : ss_next;
      ST_NORM: begin
        if (m_max[SUM_W-1:31] != '0) begin
          for (int i = 0; i < 4; i++) mag[i] <= mag[i] >> 1;
        end else if (!m_max[30]) begin
          for (int i = 0; i < 4; i++) mag[i] <= mag[i] << 1;
        end
      end
      ST_SQHI: begin
        if (ph) ss <= ss_next;
        if (sq_done) begin
          sq_v   <= ss_next;
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
        end
      end
      ST_SQRT: begin
        if (sq_v >= sq_try) begin
          sq_v <= sq_v - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sqrt_done) begin
          nrt <= (sq_v >= sq_try) ? 32'((sq_r >> 1) + sq_bit) : 32'(sq_r >> 1);
        end
      end
      ST_DIV: begin
        if (cnt == 6'd0) begin
          rem <= {1'b0, numer[61:31]};
          dsh <= numer[30:0];
          quo <= '0;
        end else begin
          rem <= rem_next;
          dsh <= {dsh[29:0], 1'b0};
          quo <= quo_next;
        end
      end
      ST_FIN: begin
        if (fin_go) out_data <= '{att_w: q[0], att_x: q[1], att_y: q[2], att_z: q[3],
                                  degenerate: deg_flag};
      end
      default: ;
    endcase
  end

  // checks
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_HAM))
    else $error("accepted beat did not start the product phase");

  a_deg_ident: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |-> (out_data.att_w == ONE_Q &&
      out_data.att_x == '0 && out_data.att_y == '0 && out_data.att_z == '0))
    else $error("degenerate beat is not identity");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt != 6'd0) |-> (rem < nrt))
    else $error("divider remainder not below divisor");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.att_w <= ONE_Q && out_data.att_w >= -ONE_Q))
    else $error("scalar part out of unit range");

endmodule

>>> rtl/core/qga_mul.sv
// ----------------------------------------------------------------------------
// qga_mul
// Shared signed multiplier with a registered product, one result a cycle.
// ----------------------------------------------------------------------------
module qga_mul
  import qga_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  // product register
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
